### src/uiqc_pkg.sv
package uiqc_pkg;

	localparam int COUNTER_BITS_DEF = 16;
	localparam int TIMER_BITS_DEF   = 16;

	localparam int CFG_BITS  = 16;
	localparam int APB_DATA  = 32;
	localparam int APB_ADDR  = 4;
	localparam int FRAME_LEN = 5;
	localparam int FILL_BITS = 3;

	localparam logic [7:0] HDR_BYTE = 8'hCC;
	localparam logic [7:0] REQ_BYTE0 = 8'hCC;
	localparam logic [7:0] REQ_BYTE1 = 8'h00;
	localparam logic [7:0] REQ_BYTE2 = 8'h60;
	localparam logic [1:0] REQ_LEN = 2'd3;
	localparam logic [7:0] CRC_POLY = 8'hD5;
	localparam logic [7:0] GOOD_VERSION = 8'd1;

	localparam logic [CFG_BITS-1:0] BOOT_WAIT_RST  = 16'd3000;
	localparam logic [CFG_BITS-1:0] SEND_LIMIT_RST = 16'd100;
	localparam logic [CFG_BITS-1:0] REPLY_LIMIT_RST = 16'd1000;
	localparam logic [CFG_BITS-1:0] BYTE_LIMIT_RST = 16'd256;

	typedef enum logic [1:0] {
		REG_BOOT_WAIT   = 2'd0,
		REG_SEND_LIMIT  = 2'd1,
		REG_REPLY_LIMIT = 2'd2,
		REG_BYTE_LIMIT  = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		CMD_START = 3'd0,
		CMD_TICK  = 3'd1,
		CMD_RX    = 3'd2,
		CMD_EMPTY = 3'd3,
		CMD_TAKEN = 3'd4,
		CMD_SENT  = 3'd5,
		CMD_FAULT = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_BOOT  = 3'd1,
		PH_DRAIN = 3'd2,
		PH_SEND  = 3'd3,
		PH_WAIT  = 3'd4,
		PH_REPLY = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_RUNNING = 2'd1,
		ST_PASSED  = 2'd2,
		ST_FAILED  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_FAULT     = 3'd1,
		ERR_BYTE_LIM  = 3'd2,
		ERR_SEND_TO   = 3'd3,
		ERR_REPLY_TO  = 3'd4,
		ERR_BAD_CRC   = 3'd5,
		ERR_VERSION   = 3'd6
	} err_t;

	typedef logic [7:0] crc_tab_t [256];

	function automatic crc_tab_t crc_tab_gen();
		crc_tab_t   t;
		logic [7:0] c;
		for (int i = 0; i < 256; i++) begin
			c = 8'(i);
			for (int b = 0; b < 8; b++) begin
				c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
			end
			t[i] = c;
		end
		return t;
	endfunction

	// byte-wise CRC-8 lookup, built at elaboration
	localparam crc_tab_t CRC_TAB = crc_tab_gen();

	function automatic logic [7:0] req_byte(input logic [1:0] idx);
		logic [7:0] r;
		unique case (idx)
			2'd0: r = REQ_BYTE0;
			2'd1: r = REQ_BYTE1;
			2'd2: r = REQ_BYTE2;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

### src/uart_info_query_controller_core.sv
// Channel  | Signals                                   | Contents
// ---------+-------------------------------------------+---------------------------------------
// event in | s_axis_tvalid/tready/tdata/tuser          | tuser: cmd; tdata: enabled, rx_data
// result   | m_axis_tvalid/tready/tdata/tlast          | one result per event; tlast = finished
// config   | psel/penable/pwrite/paddr/pwdata/prdata   | four 16-bit registers at 0x0..0xC
//
// Each event is processed at accept: state and result register update together.
// A new event is taken every cycle while the result register is empty or being drained.
// arst_n clears control state and restores register defaults; frame bytes are not reset.
// Downstream stall holds the result; s_axis_tready drops only while a result waits unread.
module uart_info_query_controller_core #(
	parameter int COUNTER_BITS = uiqc_pkg::COUNTER_BITS_DEF,
	parameter int TIMER_BITS   = uiqc_pkg::TIMER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [0] enabled, [8:1] rx_data, [15:9] zero
	input  logic [2:0]  s_axis_tuser,   // [2:0] cmd

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [1:0] status, [4:2] error, [5] power_on, [6] oe_on, [7] tx_valid, [15:8] tx_data,
	// [23:16] dev_version, [39:24] features, [55:40] bad_crc_count, [71:56] reply_bytes,
	// [87:72] discarded
	output logic [87:0] m_axis_tdata,
	output logic        m_axis_tlast,   // finished

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [uiqc_pkg::APB_ADDR-1:0] paddr,
	input  logic [uiqc_pkg::APB_DATA-1:0] pwdata,
	output logic [uiqc_pkg::APB_DATA-1:0] prdata,
	output logic        pready
);

	localparam int CW = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
	localparam int TW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
	localparam int FL = uiqc_pkg::FRAME_LEN;

	// configuration
	logic [15:0] boot_wait_q, send_limit_q, reply_limit_q, byte_limit_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_wait_q   <= uiqc_pkg::BOOT_WAIT_RST;
			send_limit_q  <= uiqc_pkg::SEND_LIMIT_RST;
			reply_limit_q <= uiqc_pkg::REPLY_LIMIT_RST;
			byte_limit_q  <= uiqc_pkg::BYTE_LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (uiqc_pkg::reg_idx_t'(paddr[3:2]))
				uiqc_pkg::REG_BOOT_WAIT:   boot_wait_q   <= pwdata[15:0];
				uiqc_pkg::REG_SEND_LIMIT:  send_limit_q  <= pwdata[15:0];
				uiqc_pkg::REG_REPLY_LIMIT: reply_limit_q <= pwdata[15:0];
				uiqc_pkg::REG_BYTE_LIMIT:  byte_limit_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (uiqc_pkg::reg_idx_t'(paddr[3:2]))
			uiqc_pkg::REG_BOOT_WAIT:   prdata = 32'(boot_wait_q);
			uiqc_pkg::REG_SEND_LIMIT:  prdata = 32'(send_limit_q);
			uiqc_pkg::REG_REPLY_LIMIT: prdata = 32'(reply_limit_q);
			uiqc_pkg::REG_BYTE_LIMIT:  prdata = 32'(byte_limit_q);
			default:                   prdata = '0;
		endcase
	end

	// run state
	uiqc_pkg::phase_t          phase_q, phase_n;
	uiqc_pkg::status_t         status_q, status_n;
	uiqc_pkg::err_t            err_q, err_n;
	logic [TIMER_BITS-1:0]     elapsed_q, elapsed_n, elapsed_tick;
	logic [2:0]                fill_q, fill_n;
	logic [1:0]                sent_q, sent_n;
	logic [COUNTER_BITS-1:0]   crc_err_q, crc_err_n;
	logic [COUNTER_BITS-1:0]   rx_cnt_q, rx_cnt_n;
	logic [COUNTER_BITS-1:0]   disc_q, disc_n;
	logic [7:0]                version_q, version_n;
	logic [15:0]               feat_q, feat_n;
	logic                      power_q, power_n;
	logic                      oe_q, oe_n;
	logic [7:0]                frame_q [FL];
	logic [7:0]                frame_n [FL];

	// request decode and handshake
	uiqc_pkg::cmd_t cmd;
	logic           en;
	logic [7:0]     rxd;
	logic           accept;
	logic           m_valid_q;

	assign cmd           = uiqc_pkg::cmd_t'(s_axis_tuser);
	assign en            = s_axis_tdata[0];
	assign rxd           = s_axis_tdata[8:1];
	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	function automatic logic [COUNTER_BITS-1:0] sat_add(
		input logic [COUNTER_BITS-1:0] a,
		input logic [2:0]              b
	);
		logic [COUNTER_BITS:0] s;
		s = {1'b0, a} + (COUNTER_BITS+1)'(b);
		return s[COUNTER_BITS] ? '1 : s[COUNTER_BITS-1:0];
	endfunction

	// frame check path
	logic [8*FL-1:0] full_v, shift_v;
	logic [7:0]      crc;
	logic [2:0]      nx;

	always_comb begin
		for (int k = 0; k < FL - 1; k++) begin
			full_v[8*k +: 8] = frame_q[k];
		end
		full_v[8*(FL-1) +: 8] = rxd;
		crc = uiqc_pkg::CRC_TAB[uiqc_pkg::CRC_TAB[uiqc_pkg::CRC_TAB[
			uiqc_pkg::CRC_TAB[frame_q[0]] ^ frame_q[1]] ^ frame_q[2]] ^ frame_q[3]];
		// resync point: first later header held in the candidate
		priority if (frame_q[1] == uiqc_pkg::HDR_BYTE) nx = 3'd1;
		else if (frame_q[2] == uiqc_pkg::HDR_BYTE)     nx = 3'd2;
		else if (frame_q[3] == uiqc_pkg::HDR_BYTE)     nx = 3'd3;
		else if (rxd == uiqc_pkg::HDR_BYTE)            nx = 3'd4;
		else                                           nx = 3'd5;
		shift_v = full_v >> {nx, 3'b000};
	end

	logic          do_fin, fin;
	uiqc_pkg::err_t fin_err;
	logic          uart_phase;

	assign elapsed_tick = (elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q;
	assign uart_phase   = (phase_q == uiqc_pkg::PH_DRAIN) || (phase_q == uiqc_pkg::PH_SEND) ||
	                      (phase_q == uiqc_pkg::PH_WAIT) || (phase_q == uiqc_pkg::PH_REPLY);

	always_comb begin
		phase_n   = phase_q;
		status_n  = status_q;
		err_n     = err_q;
		elapsed_n = elapsed_q;
		fill_n    = fill_q;
		sent_n    = sent_q;
		crc_err_n = crc_err_q;
		rx_cnt_n  = rx_cnt_q;
		disc_n    = disc_q;
		version_n = version_q;
		feat_n    = feat_q;
		power_n   = power_q;
		oe_n      = oe_q;
		frame_n   = frame_q;
		do_fin    = 1'b0;
		fin_err   = uiqc_pkg::ERR_NONE;
		fin       = 1'b0;

		if (cmd == uiqc_pkg::CMD_START) begin
			phase_n   = uiqc_pkg::PH_IDLE;
			status_n  = uiqc_pkg::ST_IDLE;
			err_n     = uiqc_pkg::ERR_NONE;
			elapsed_n = '0;
			fill_n    = '0;
			sent_n    = '0;
			crc_err_n = '0;
			rx_cnt_n  = '0;
			disc_n    = '0;
			version_n = '0;
			feat_n    = '0;
			oe_n      = 1'b0;
			power_n   = 1'b0;
			if (!en) begin
				fin = 1'b1;
			end else begin
				status_n = uiqc_pkg::ST_RUNNING;
				power_n  = 1'b1;
				phase_n  = uiqc_pkg::PH_BOOT;
				if (boot_wait_q == '0) begin
					oe_n    = 1'b1;
					phase_n = uiqc_pkg::PH_DRAIN;
				end
			end
		end else if (cmd == uiqc_pkg::CMD_FAULT) begin
			if (uart_phase) begin
				do_fin  = 1'b1;
				fin_err = uiqc_pkg::ERR_FAULT;
			end
		end else begin
			unique case (phase_q)
				uiqc_pkg::PH_BOOT: begin
					if (cmd == uiqc_pkg::CMD_TICK) begin
						elapsed_n = elapsed_tick;
						if (TW'(elapsed_tick) >= TW'(boot_wait_q)) begin
							oe_n      = 1'b1;
							elapsed_n = '0;
							phase_n   = uiqc_pkg::PH_DRAIN;
						end
					end
				end
				uiqc_pkg::PH_DRAIN: begin
					if (cmd == uiqc_pkg::CMD_TICK) begin
						elapsed_n = elapsed_tick;
					end else if (cmd == uiqc_pkg::CMD_RX) begin
						disc_n = sat_add(disc_q, 3'd1);
						if (CW'(disc_n) >= CW'(byte_limit_q) ||
						    TW'(elapsed_q) >= TW'(send_limit_q)) begin
							do_fin  = 1'b1;
							fin_err = uiqc_pkg::ERR_BYTE_LIM;
						end
					end else if (cmd == uiqc_pkg::CMD_EMPTY) begin
						elapsed_n = '0;
						sent_n    = '0;
						phase_n   = uiqc_pkg::PH_SEND;
					end
				end
				uiqc_pkg::PH_SEND, uiqc_pkg::PH_WAIT: begin
					if (cmd == uiqc_pkg::CMD_TICK) begin
						elapsed_n = elapsed_tick;
						if (TW'(elapsed_tick) >= TW'(send_limit_q)) begin
							do_fin  = 1'b1;
							fin_err = uiqc_pkg::ERR_SEND_TO;
						end
					end else if (cmd == uiqc_pkg::CMD_TAKEN &&
					             phase_q == uiqc_pkg::PH_SEND) begin
						if (sent_q >= uiqc_pkg::REQ_LEN - 2'd1) begin
							sent_n  = uiqc_pkg::REQ_LEN;
							phase_n = uiqc_pkg::PH_WAIT;
						end else begin
							sent_n = sent_q + 2'd1;
						end
					end else if (cmd == uiqc_pkg::CMD_SENT &&
					             phase_q == uiqc_pkg::PH_WAIT) begin
						elapsed_n = '0;
						fill_n    = '0;
						phase_n   = uiqc_pkg::PH_REPLY;
					end
				end
				uiqc_pkg::PH_REPLY: begin
					if (cmd == uiqc_pkg::CMD_TICK) begin
						elapsed_n = elapsed_tick;
						if (TW'(elapsed_tick) >= TW'(reply_limit_q)) begin
							do_fin  = 1'b1;
							fin_err = (crc_err_q != '0) ? uiqc_pkg::ERR_BAD_CRC :
							                              uiqc_pkg::ERR_REPLY_TO;
						end
					end else if (cmd == uiqc_pkg::CMD_RX) begin
						rx_cnt_n = sat_add(rx_cnt_q, 3'd1);
						if (fill_q == '0 && rxd != uiqc_pkg::HDR_BYTE) begin
							disc_n = sat_add(disc_q, 3'd1);
						end else if (fill_q != 3'(FL - 1)) begin
							frame_n[fill_q] = rxd;
							fill_n          = fill_q + 3'd1;
						end else if (crc == rxd) begin
							version_n = frame_q[1];
							feat_n    = {frame_q[3], frame_q[2]};
							do_fin    = 1'b1;
							fin_err   = (frame_q[1] != uiqc_pkg::GOOD_VERSION) ?
							            uiqc_pkg::ERR_VERSION : uiqc_pkg::ERR_NONE;
						end else begin
							crc_err_n = sat_add(crc_err_q, 3'd1);
							disc_n    = sat_add(disc_q, nx);
							fill_n    = 3'(FL) - nx;
							for (int k = 0; k < FL; k++) begin
								frame_n[k] = shift_v[8*k +: 8];
							end
						end
						// a good frame ends the run before the byte limit is looked at
						if (!do_fin && CW'(rx_cnt_n) >= CW'(byte_limit_q)) begin
							do_fin  = 1'b1;
							fin_err = uiqc_pkg::ERR_BYTE_LIM;
						end
					end
				end
				default: ;
			endcase
		end

		if (do_fin) begin
			err_n    = fin_err;
			oe_n     = 1'b0;
			status_n = (fin_err != uiqc_pkg::ERR_NONE) ? uiqc_pkg::ST_FAILED :
			                                             uiqc_pkg::ST_PASSED;
			phase_n  = uiqc_pkg::PH_IDLE;
			fin      = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= uiqc_pkg::PH_IDLE;
			status_q  <= uiqc_pkg::ST_IDLE;
			err_q     <= uiqc_pkg::ERR_NONE;
			elapsed_q <= '0;
			fill_q    <= '0;
			sent_q    <= '0;
			crc_err_q <= '0;
			rx_cnt_q  <= '0;
			disc_q    <= '0;
			version_q <= '0;
			feat_q    <= '0;
			power_q   <= 1'b0;
			oe_q      <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_n;
			status_q  <= status_n;
			err_q     <= err_n;
			elapsed_q <= elapsed_n;
			fill_q    <= fill_n;
			sent_q    <= sent_n;
			crc_err_q <= crc_err_n;
			rx_cnt_q  <= rx_cnt_n;
			disc_q    <= disc_n;
			version_q <= version_n;
			feat_q    <= feat_n;
			power_q   <= power_n;
			oe_q      <= oe_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			frame_q <= frame_n;
		end
	end

	// result register
	logic          tx_valid;
	logic [7:0]    tx_data;
	logic [CW-1:0] crc_err_w, rx_cnt_w, disc_w;
	logic [87:0]   m_data_q;
	logic          m_last_q;

	assign tx_valid  = (phase_n == uiqc_pkg::PH_SEND) && (sent_n < uiqc_pkg::REQ_LEN);
	assign tx_data   = tx_valid ? uiqc_pkg::req_byte(sent_n) : 8'h00;
	assign crc_err_w = CW'(crc_err_n);
	assign rx_cnt_w  = CW'(rx_cnt_n);
	assign disc_w    = CW'(disc_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= {disc_w[15:0], rx_cnt_w[15:0], crc_err_w[15:0], feat_n, version_n,
			             tx_data, tx_valid, oe_n, power_n, err_n, status_n};
			m_last_q <= fin;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

endmodule
